// ----- rtl/gas_level_slope_classifier_top_assert.svh -----
// Assertion macros shared by the checker of the gas level slope classifier.
`ifndef GAS_LEVEL_SLOPE_CLASSIFIER_TOP_ASSERT_SVH
`define GAS_LEVEL_SLOPE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define GLSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define GLSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/glsc_pkg.sv -----
// Package with widths, codes and reset values of the gas level slope classifier.
`timescale 1ns / 1ps
`default_nettype none
package glsc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 20;
  localparam int TIME_W      = 32;
  localparam int SUM_W       = 32;
  localparam int REG_W       = 12;
  localparam int CLASS_W     = 3;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = ADDR_W - 2;

  // One serial step per bit of the 32-bit sum and time words.
  localparam int STEP_CNT_W  = $clog2(SUM_W);
  localparam int SMP_IDX_W   = $clog2(SAMPLE_BITS);
  localparam int CMP_W       = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
  localparam int REM_W       = COUNT_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [CLASS_W-1:0] CLASS_FRESH       = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_LOW         = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_HIGH        = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_FORCE       = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_NOT_STARTED = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_JUMP_THR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEV_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEV_LOW    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_LOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_START_HIGH = 3'd5;

  localparam logic [REG_W-1:0]  RST_JUMP_THR   = 12'd400;
  localparam logic [REG_W-1:0]  RST_DEV_HIGH   = 12'd150;
  localparam logic [REG_W-1:0]  RST_DEV_LOW    = 12'd50;
  localparam logic [TIME_W-1:0] RST_PERIOD     = 32'd500000;
  localparam logic [REG_W-1:0]  RST_START_LOW  = 12'd10;
  localparam logic [REG_W-1:0]  RST_START_HIGH = 12'd798;

endpackage
`default_nettype wire

// ----- rtl/gas_level_slope_classifier_top.sv -----
// Gas level slope classifier: bit-serial baseline tracker and air class decision.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// Input channel (in_valid_i / in_ready_o) carries one converter sample with its
// millisecond timestamp; output channel (out_valid_o / out_ready_i) returns one
// result per sample: air class, current level and the baseline used.
// Thresholds, baseline period and start window sit in an APB register file
// (byte address 4*i); write them only while the block is idle.
// Order: a sample seen before start passes from the transfer straight to the
// done state. After start, the running sum and the time difference are handled
// one bit per cycle over all 32 bits in the add state; when the baseline is
// recomputed a restoring divider then adds one quotient bit per cycle over the
// 12 quotient bits. One sample is in work at a time: a new sample is taken only
// when the previous one has left the serial adder and the divider and its
// result has been placed in the output register.
// Reset clears the levels, sum, count and start flag and loads the register
// reset values. A stalled receiver holds the result in the output register;
// the next sample is still taken and processed, then waits for that register.
module gas_level_slope_classifier_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [glsc_pkg::SAMPLE_BITS-1:0]      sample_i,
  input  logic [glsc_pkg::TIME_W-1:0]           now_ms_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [glsc_pkg::CLASS_W-1:0]          air_class_o,
  output logic [glsc_pkg::SAMPLE_BITS-1:0]      level_now_o,
  output logic [glsc_pkg::SAMPLE_BITS-1:0]      baseline_now_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [glsc_pkg::ADDR_W-1:0]           paddr,
  input  logic [glsc_pkg::DATA_W-1:0]           pwdata,
  output logic [glsc_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);
  import glsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [STEP_CNT_W-1:0] ADD_LAST = STEP_CNT_W'(SUM_W - 1);
  localparam logic [STEP_CNT_W-1:0] DIV_LAST = STEP_CNT_W'(SAMPLE_BITS - 1);

  // Configuration registers.
  logic [REG_W-1:0]  jump_thr_q, dev_high_q, dev_low_q, start_low_q, start_high_q;
  logic [TIME_W-1:0] period_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic              cfg_wr;

  // Control and model state.
  logic [1:0]              state_q, state_d;
  logic [STEP_CNT_W-1:0]   step_q, step_d;
  logic                    carry_q, carry_d, borrow_q, borrow_d, gt_q, gt_d;
  logic                    started_q, started_d;
  logic [SAMPLE_BITS-1:0]  cur_q, cur_d, prev_q, prev_d, base_q, base_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic [TIME_W-1:0]       last_q, last_d;
  logic                    out_valid_q, out_valid_d;

  // Payload registers.
  logic [SAMPLE_BITS-1:0]  smp_q, smp_d;
  logic [TIME_W-1:0]       now_q, now_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic [SAMPLE_BITS-1:0]  quo_q, quo_d;
  logic [CLASS_W-1:0]      cls_q, cls_d;
  logic [SAMPLE_BITS-1:0]  lvl_out_q, lvl_out_d, base_out_q, base_out_d;

  // Serial datapath signals.
  logic                    smp_bit, sum_bit, carry_n;
  logic                    now_bit, last_bit, per_bit, diff_bit, borrow_n, gt_n;
  logic [SUM_W-1:0]        sum_shift, sum_fin;
  logic [COUNT_BITS-1:0]   count_inc;
  logic                    recompute;
  logic [REM_W-1:0]        rem_sh, div_den;
  logic                    div_ge;
  logic                    in_xfer, out_free;

  // Classification signals.
  logic [CMP_W-1:0]        smp_c, lo_c, hi_c, cur_c, prev_c, base_c;
  logic signed [CMP_W:0]   jump_s, dev_s, jt_s, dh_s, dl_s;
  logic                    in_window, jump_big, dev_hi, dev_lo;
  logic [CLASS_W-1:0]      run_class;

  // Register file.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_JUMP_THR:   prdata = DATA_W'(jump_thr_q);
      REG_DEV_HIGH:   prdata = DATA_W'(dev_high_q);
      REG_DEV_LOW:    prdata = DATA_W'(dev_low_q);
      REG_PERIOD:     prdata = DATA_W'(period_q);
      REG_START_LOW:  prdata = DATA_W'(start_low_q);
      REG_START_HIGH: prdata = DATA_W'(start_high_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_thr_q   <= RST_JUMP_THR;
      dev_high_q   <= RST_DEV_HIGH;
      dev_low_q    <= RST_DEV_LOW;
      period_q     <= RST_PERIOD;
      start_low_q  <= RST_START_LOW;
      start_high_q <= RST_START_HIGH;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_JUMP_THR:   jump_thr_q   <= pwdata[REG_W-1:0];
        REG_DEV_HIGH:   dev_high_q   <= pwdata[REG_W-1:0];
        REG_DEV_LOW:    dev_low_q    <= pwdata[REG_W-1:0];
        REG_PERIOD:     period_q     <= pwdata[TIME_W-1:0];
        REG_START_LOW:  start_low_q  <= pwdata[REG_W-1:0];
        REG_START_HIGH: start_high_q <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes.
  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_xfer        = in_valid_i && in_ready_o;
  assign out_free       = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign air_class_o    = cls_q;
  assign level_now_o    = lvl_out_q;
  assign baseline_now_o = base_out_q;

  // One bit of the sum, the time difference and the period compare per step.
  assign smp_bit   = (step_q < STEP_CNT_W'(SAMPLE_BITS)) ?
                     smp_q[step_q[SMP_IDX_W-1:0]] : 1'b0;
  assign sum_bit   = sum_q[0] ^ smp_bit ^ carry_q;
  assign carry_n   = (sum_q[0] & smp_bit) | (carry_q & (sum_q[0] ^ smp_bit));
  assign now_bit   = now_q[step_q];
  assign last_bit  = last_q[step_q];
  assign per_bit   = period_q[step_q];
  assign diff_bit  = now_bit ^ last_bit ^ borrow_q;
  assign borrow_n  = (~now_bit & last_bit) | (~(now_bit ^ last_bit) & borrow_q);
  // LSB-first magnitude compare: a higher differing bit overrides the rest.
  assign gt_n      = (diff_bit & ~per_bit) | (~(diff_bit ^ per_bit) & gt_q);
  assign sum_shift = {sum_bit, sum_q[SUM_W-1:1]};
  assign sum_fin   = carry_n ? '1 : sum_shift;
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
  assign recompute = gt_n || (count_inc == COUNT_MAX);

  // Restoring divider step; the quotient fits the sample width, so the
  // upper dividend bits start out as the partial remainder.
  assign rem_sh  = {rem_q[REM_W-2:0], sum_q[SAMPLE_BITS-1]};
  assign div_den = {1'b0, count_q};
  assign div_ge  = (rem_sh >= div_den);

  // Start window and classification.
  assign smp_c     = CMP_W'(smp_q);
  assign lo_c      = CMP_W'(start_low_q);
  assign hi_c      = CMP_W'(start_high_q);
  assign in_window = (smp_c > lo_c) && (smp_c < hi_c);
  assign cur_c     = CMP_W'(cur_q);
  assign prev_c    = CMP_W'(prev_q);
  assign base_c    = CMP_W'(base_q);
  assign jump_s    = $signed({1'b0, cur_c}) - $signed({1'b0, prev_c});
  assign dev_s     = $signed({1'b0, cur_c}) - $signed({1'b0, base_c});
  assign jt_s      = $signed({1'b0, CMP_W'(jump_thr_q)});
  assign dh_s      = $signed({1'b0, CMP_W'(dev_high_q)});
  assign dl_s      = $signed({1'b0, CMP_W'(dev_low_q)});
  assign jump_big  = (jump_s > jt_s);
  assign dev_hi    = (dev_s > dh_s);
  assign dev_lo    = (dev_s > dl_s);

  always_comb begin
    if (jump_big && dev_hi) begin
      run_class = CLASS_FORCE;
    end else if ((jump_big && dev_lo) || dev_hi) begin
      run_class = CLASS_HIGH;
    end else if (dev_lo) begin
      run_class = CLASS_LOW;
    end else begin
      run_class = CLASS_FRESH;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    carry_d     = carry_q;
    borrow_d    = borrow_q;
    gt_d        = gt_q;
    started_d   = started_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    base_d      = base_q;
    sum_d       = sum_q;
    count_d     = count_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    smp_d       = smp_q;
    now_d       = now_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cls_d       = cls_q;
    lvl_out_d   = lvl_out_q;
    base_out_d  = base_out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          smp_d    = sample_i;
          now_d    = now_ms_i;
          step_d   = '0;
          carry_d  = 1'b0;
          borrow_d = 1'b0;
          gt_d     = 1'b0;
          if (started_q) begin
            prev_d  = cur_q;
            cur_d   = sample_i;
            state_d = ST_ADD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_ADD: begin
        carry_d  = carry_n;
        borrow_d = borrow_n;
        gt_d     = gt_n;
        step_d   = step_q + 1'b1;
        sum_d    = sum_shift;
        if (step_q == ADD_LAST) begin
          sum_d   = sum_fin;
          count_d = count_inc;
          step_d  = '0;
          if (recompute) begin
            rem_d   = REM_W'(sum_fin >> SAMPLE_BITS);
            state_d = ST_DIV;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        rem_d  = div_ge ? (rem_sh - div_den) : rem_sh;
        quo_d  = {quo_q[SAMPLE_BITS-2:0], div_ge};
        sum_d  = sum_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == DIV_LAST) begin
          base_d  = {quo_q[SAMPLE_BITS-2:0], div_ge};
          last_d  = now_q;
          sum_d   = '0;
          count_d = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (started_q) begin
            cls_d      = run_class;
            lvl_out_d  = cur_q;
            base_out_d = base_q;
          end else if (in_window) begin
            started_d  = 1'b1;
            cur_d      = smp_q;
            prev_d     = smp_q;
            base_d     = smp_q;
            last_d     = now_q;
            cls_d      = CLASS_FRESH;
            lvl_out_d  = smp_q;
            base_out_d = smp_q;
          end else begin
            cls_d      = CLASS_NOT_STARTED;
            lvl_out_d  = cur_q;
            base_out_d = base_q;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      carry_q     <= 1'b0;
      borrow_q    <= 1'b0;
      gt_q        <= 1'b0;
      started_q   <= 1'b0;
      cur_q       <= '0;
      prev_q      <= '0;
      base_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      carry_q     <= carry_d;
      borrow_q    <= borrow_d;
      gt_q        <= gt_d;
      started_q   <= started_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      base_q      <= base_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    now_q      <= now_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    cls_q      <= cls_d;
    lvl_out_q  <= lvl_out_d;
    base_out_q <= base_out_d;
  end

endmodule
`default_nettype wire

// ----- rtl/glsc_checker.sv -----
// Port-level checker for the gas level slope classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "gas_level_slope_classifier_top_assert.svh"
module glsc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [glsc_pkg::CLASS_W-1:0]      air_class_o,
  input logic                              pready
);
  import glsc_pkg::*;

  // A held result keeps its class until the transfer completes.
  `GLSC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(air_class_o), "result changed while stalled")
  // Only one sample is in work, so a transfer makes the input side busy.
  `GLSC_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "input ready right after a transfer")
  `GLSC_ASSERT_NOW(a_class_range, out_valid_o, air_class_o <= CLASS_NOT_STARTED, "air class code out of range")
  `GLSC_ASSERT_NOW(a_pready, 1'b1, pready, "register port not ready")

endmodule

bind gas_level_slope_classifier_top glsc_checker u_glsc_checker (.*);
`default_nettype wire
